[rtl/core/clc_pkg.sv]
package clc_pkg;

   // input item kinds (req_tuser)
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // command characters accepted in idle
   localparam logic [7:0] CMD_OPEN   = 8'h2B;  // '+'
   localparam logic [7:0] CMD_CHANGE = 8'h2D;  // '-'

   // motor drive codes
   localparam logic [1:0] DRIVE_STOP = 2'd0;
   localparam logic [1:0] DRIVE_CW   = 2'd1;
   localparam logic [1:0] DRIVE_ACW  = 2'd2;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_ADDR_W-1:0] REG_CW_END       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLD_END     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CLOSE_END    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ALARM_END    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_FAILURES = 3'd4;

   localparam logic [7:0] CW_END_RESET       = 8'd30;
   localparam logic [7:0] HOLD_END_RESET     = 8'd36;
   localparam logic [7:0] CLOSE_END_RESET    = 8'd66;
   localparam logic [7:0] ALARM_END_RESET    = 8'd120;
   localparam logic [3:0] MAX_FAILURES_RESET = 4'd3;

   typedef struct packed {
      logic [7:0] cw_end;
      logic [7:0] hold_end;
      logic [7:0] close_end;
      logic [7:0] alarm_end;
      logic [3:0] max_failures;
   } clc_cfg_type;

   // from the code sequencer to the timing unit, valid for one accepted item
   typedef struct packed {
      logic tick;
      logic motor_start;
      logic alarm_start;
   } clc_timer_ctl_type;

   // timing unit outputs as they stand after the current item
   typedef struct packed {
      logic [1:0] motor_drive;
      logic       siren_on;
   } clc_timer_status_type;

endpackage

[rtl/core/clc_timer.sv]
module clc_timer
   import clc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  clc_cfg_type          cfg,
   input  clc_timer_ctl_type    ctl,
   output clc_timer_status_type status
);

   logic [7:0] motor_ticks_ff, motor_ticks_in;
   logic       motor_active_ff, motor_active_in;
   logic [1:0] motor_level_ff, motor_level_in;
   logic [7:0] alarm_ticks_ff, alarm_ticks_in;
   logic       alarm_active_ff, alarm_active_in;
   logic [7:0] motor_next;
   logic [7:0] alarm_next;

   assign motor_next = motor_ticks_ff + 8'd1;
   assign alarm_next = alarm_ticks_ff + 8'd1;

   always_comb begin
      motor_ticks_in  = motor_ticks_ff;
      motor_active_in = motor_active_ff;
      motor_level_in  = motor_level_ff;
      alarm_ticks_in  = alarm_ticks_ff;
      alarm_active_in = alarm_active_ff;

      // a start while running leaves the run untouched
      if (ctl.motor_start && !motor_active_ff) begin
         motor_active_in = 1'b1;
         motor_ticks_in  = '0;
      end
      if (ctl.alarm_start && !alarm_active_ff) begin
         alarm_active_in = 1'b1;
         alarm_ticks_in  = '0;
      end

      if (ctl.tick && motor_active_ff) begin
         motor_ticks_in = motor_next;
         if (motor_next == cfg.close_end) begin
            motor_level_in  = DRIVE_STOP;
            motor_active_in = 1'b0;
            motor_ticks_in  = '0;
         end else if (motor_next < cfg.cw_end) begin
            motor_level_in = DRIVE_CW;
         end else if (motor_next < cfg.hold_end) begin
            motor_level_in = DRIVE_STOP;
         end else begin
            motor_level_in = DRIVE_ACW;
         end
      end

      if (ctl.tick && alarm_active_ff) begin
         alarm_ticks_in = alarm_next;
         if (alarm_next == cfg.alarm_end) begin
            alarm_active_in = 1'b0;
            alarm_ticks_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_ticks_ff  <= '0;
         motor_active_ff <= 1'b0;
         motor_level_ff  <= DRIVE_STOP;
         alarm_ticks_ff  <= '0;
         alarm_active_ff <= 1'b0;
      end else begin
         motor_ticks_ff  <= motor_ticks_in;
         motor_active_ff <= motor_active_in;
         motor_level_ff  <= motor_level_in;
         alarm_ticks_ff  <= alarm_ticks_in;
         alarm_active_ff <= alarm_active_in;
      end
   end

   // buzzer sounds from the first tick of a run
   assign status.motor_drive = motor_level_in;
   assign status.siren_on    = alarm_active_in && (alarm_ticks_in != 8'd0);

endmodule

[rtl/core/code_lock_controller.sv]
// combination lock controller
//
// req channel: one transfer per item; req_tuser says what it is (0 = received
// byte in req_tdata, 1 = timer tick, req_tdata ignored). after reset the lock
// wants a new code entered twice; in idle '+' starts an open check and '-' a
// code change check, each over CODE_DIGITS bytes.
// rsp channel: exactly one transfer per req transfer, in order, carrying the
// reply flag and code plus the current motor drive and buzzer state.
// csr port: csr_we writes csr_wdata into register csr_addr in the same edge;
// only write while no item is in flight.
// result: registered in the output register, or in the skid register while
// the output one stalls. throughput: one item per cycle while req_tready is
// high, set by the single registered pass from state and input to the result.
// stall: results queue in a two-entry output buffer (output register plus
// skid register); req_tready drops only while both hold a result.
// reset: synchronous; registers take their default timings, the lock goes
// back to code setup, motor and alarm stop, the output buffer empties.
// the code stores have no reset and are written during setup.
module code_lock_controller
   import clc_pkg::*;
#(
   parameter int CODE_DIGITS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] byte_value
   input  logic                  req_tuser,   // [0] opcode
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] reply_valid, [1] reply_code,
                                              // [3:2] motor_drive, [4] siren_on,
                                              // [7:5] zero
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

   typedef enum logic [2:0] {
      SETUP_FIRST,
      SETUP_SECOND,
      IDLE,
      OPEN_CHECK,
      CHANGE_CHECK
   } mode_type;

   // ---------------- configuration registers ----------------
   clc_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cw_end       <= CW_END_RESET;
         cfg_ff.hold_end     <= HOLD_END_RESET;
         cfg_ff.close_end    <= CLOSE_END_RESET;
         cfg_ff.alarm_end    <= ALARM_END_RESET;
         cfg_ff.max_failures <= MAX_FAILURES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_CW_END:       cfg_ff.cw_end       <= csr_wdata;
            REG_HOLD_END:     cfg_ff.hold_end     <= csr_wdata;
            REG_CLOSE_END:    cfg_ff.close_end    <= csr_wdata;
            REG_ALARM_END:    cfg_ff.alarm_end    <= csr_wdata;
            REG_MAX_FAILURES: cfg_ff.max_failures <= csr_wdata[3:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic       out_valid_ff, skid_valid_ff;
   logic [7:0] out_data_ff, skid_data_ff;
   logic       accept;
   logic       out_fire;
   logic       is_byte;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_fire   = out_valid_ff && rsp_tready;
   assign is_byte    = (req_tuser == OP_BYTE);

   // ---------------- code sequencer ----------------
   // two code banks: bank_sel_ff points at the stored code, the other bank
   // takes the first setup entry, so a confirmed code only flips the pointer
   logic [7:0]       bank0_ff [CODE_DIGITS];
   logic [7:0]       bank1_ff [CODE_DIGITS];
   logic             bank_sel_ff, bank_sel_in;
   logic             bank_we;
   logic [7:0]       bank0_rd, bank1_rd;
   logic [7:0]       first_rd, stored_rd;

   mode_type         mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             mismatch_ff, mismatch_in;
   logic [3:0]       fails_ff, fails_in;
   logic [3:0]       fails_inc;
   logic             last_digit;
   logic             miss;
   logic             reply_valid, reply_code;
   logic             motor_start, alarm_start;

   assign bank0_rd  = bank0_ff[idx_ff];
   assign bank1_rd  = bank1_ff[idx_ff];
   assign first_rd  = bank_sel_ff ? bank0_rd : bank1_rd;
   assign stored_rd = bank_sel_ff ? bank1_rd : bank0_rd;

   assign last_digit = (idx_ff == LAST_IDX);
   assign fails_inc  = fails_ff + 4'd1;

   always_comb begin
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      mismatch_in = mismatch_ff;
      fails_in    = fails_ff;
      bank_sel_in = bank_sel_ff;
      bank_we     = 1'b0;
      reply_valid = 1'b0;
      reply_code  = 1'b0;
      motor_start = 1'b0;
      alarm_start = 1'b0;
      miss        = 1'b0;

      if (accept && is_byte) begin
         case (mode_ff)
            SETUP_FIRST: begin
               bank_we = 1'b1;
               if (last_digit) begin
                  idx_in      = '0;
                  mismatch_in = 1'b0;
                  mode_in     = SETUP_SECOND;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            SETUP_SECOND: begin
               miss = mismatch_ff || (first_rd != req_tdata);
               if (last_digit) begin
                  reply_valid = 1'b1;
                  reply_code  = miss;
                  idx_in      = '0;
                  mismatch_in = 1'b0;
                  if (miss) begin
                     mode_in = SETUP_FIRST;
                  end else begin
                     bank_sel_in = !bank_sel_ff;
                     mode_in     = IDLE;
                  end
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  mismatch_in = miss;
               end
            end
            IDLE: begin
               if (req_tdata == CMD_OPEN) begin
                  mode_in     = OPEN_CHECK;
                  idx_in      = '0;
                  mismatch_in = 1'b0;
               end else if (req_tdata == CMD_CHANGE) begin
                  mode_in     = CHANGE_CHECK;
                  idx_in      = '0;
                  mismatch_in = 1'b0;
               end
            end
            OPEN_CHECK, CHANGE_CHECK: begin
               miss = mismatch_ff || (stored_rd != req_tdata);
               if (last_digit) begin
                  reply_valid = 1'b1;
                  reply_code  = miss;
                  idx_in      = '0;
                  mismatch_in = 1'b0;
                  if (miss) begin
                     // failed check repeats unless the failure limit is hit
                     fails_in = fails_inc;
                     if (fails_inc == cfg_ff.max_failures) begin
                        fails_in    = '0;
                        alarm_start = 1'b1;
                        mode_in     = IDLE;
                     end
                  end else begin
                     fails_in = '0;
                     if (mode_ff == OPEN_CHECK) begin
                        motor_start = 1'b1;
                        mode_in     = IDLE;
                     end else begin
                        mode_in = SETUP_FIRST;
                     end
                  end
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  mismatch_in = miss;
               end
            end
            default: begin
               mode_in     = IDLE;
               idx_in      = '0;
               mismatch_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= SETUP_FIRST;
         idx_ff      <= '0;
         mismatch_ff <= 1'b0;
         fails_ff    <= '0;
         bank_sel_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         idx_ff      <= idx_in;
         mismatch_ff <= mismatch_in;
         fails_ff    <= fails_in;
         bank_sel_ff <= bank_sel_in;
      end
   end

   // code banks, no reset
   always_ff @(posedge clock) begin
      if (bank_we) begin
         if (bank_sel_ff) begin
            bank0_ff[idx_ff] <= req_tdata;
         end else begin
            bank1_ff[idx_ff] <= req_tdata;
         end
      end
   end

   // ---------------- motor and alarm timing ----------------
   clc_timer_ctl_type    timer_ctl;
   clc_timer_status_type timer_status;

   assign timer_ctl.tick        = accept && !is_byte;
   assign timer_ctl.motor_start = motor_start;
   assign timer_ctl.alarm_start = alarm_start;

   clc_timer u_timer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .ctl    (timer_ctl),
      .status (timer_status)
   );

   // ---------------- result buffer ----------------
   logic [7:0] result;

   assign result = {3'b000, timer_status.siren_on, timer_status.motor_drive,
                    reply_code, reply_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // input side is closed; drain the skid into the output register
         if (out_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[rtl/core/clc_checker.sv]
module clc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // reset empties the result buffer and opens the input side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result buffer not empty after reset");

   // a failure code only comes with a reply
   a_code_needs_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || !rsp_tdata[1]))
      else $error("reply code set without reply");

   // drive code is stop, clockwise or anticlockwise, pad bits zero
   a_drive_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:2] != 2'b11 && rsp_tdata[7:5] == 3'b000))
      else $error("illegal result encoding");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind code_lock_controller clc_checker u_clc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import clc_pkg::*;

   localparam int CODE_DIGITS  = 5;
   localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
   localparam int SETTLE_TICKS = 8;     // result buffer is two deep
   localparam int PHASES       = 6;
   localparam int HALF_PHASE   = 102;

   // lock sequencer position, mirrors the block's own notion of where it is
   typedef enum logic [2:0] {
      LOCK_SETUP_FIRST,
      LOCK_SETUP_SECOND,
      LOCK_IDLE,
      LOCK_OPEN_CHECK,
      LOCK_CHANGE_CHECK
   } lock_mode_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] byte_value;
   } lock_item_type;

   typedef struct packed {
      logic       reply_valid;
      logic       reply_code;
      logic [1:0] motor_drive;
      logic       siren_on;
   } lock_reply_type;

   // full predicted state of the lock, timing registers included
   typedef struct packed {
      clc_cfg_type                 cfg;
      logic [CODE_DIGITS-1:0][7:0] code_store;
      logic [CODE_DIGITS-1:0][7:0] entry_buf;
      lock_mode_type               mode;
      logic [3:0]                  digit_pos;
      logic                        mismatch;
      logic [3:0]                  fail_count;
      logic [7:0]                  motor_cnt;
      logic                        motor_run;
      logic [1:0]                  motor_lvl;
      logic [7:0]                  alarm_cnt;
      logic                        alarm_run;
   } lock_state_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [7:0] byte_value
   logic                  req_tuser  = 1'b0; // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [0] reply_valid, [1] reply_code,
                                             // [3:2] motor_drive, [4] siren_on
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // two copies of the lock state: one runs ahead while stimulus is built so that
   // sequences can follow the lock's mode, one advances on each accepted transfer
   lock_state_type gen_view;
   lock_state_type dut_view;

   lock_item_type  lock_inputs_q[$];   // items waiting for the driver
   lock_reply_type replies_due[$];     // predicted results, oldest first
   lock_item_type  in_flight;          // item currently offered on req

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int tick_mix_pct   = 0;          // chance of ticks slipped in ahead of a digit
   int planned        = 0;          // items queued that the lock does not simply ignore
   int error_total    = 0;
   int quiet_cycles   = 0;
   int items_sent     = 0;
   int ticks_sent     = 0;
   int checks_ok      = 0;
   int checks_bad     = 0;
   int buzzer_seen    = 0;

   code_lock_controller #(
      .CODE_DIGITS (CODE_DIGITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   function automatic lock_state_type lock_reset_state();
      lock_state_type st;
      st                  = '0;
      st.cfg.cw_end       = CW_END_RESET;
      st.cfg.hold_end     = HOLD_END_RESET;
      st.cfg.close_end    = CLOSE_END_RESET;
      st.cfg.alarm_end    = ALARM_END_RESET;
      st.cfg.max_failures = MAX_FAILURES_RESET;
      st.mode             = LOCK_SETUP_FIRST;
      st.motor_lvl        = DRIVE_STOP;
      return st;
   endfunction

   function automatic void apply_reg(inout lock_state_type st,
                                     input logic [CSR_ADDR_W-1:0] addr,
                                     input logic [CSR_DATA_W-1:0] value);
      case (addr)
         REG_CW_END:       st.cfg.cw_end       = value;
         REG_HOLD_END:     st.cfg.hold_end     = value;
         REG_CLOSE_END:    st.cfg.close_end    = value;
         REG_ALARM_END:    st.cfg.alarm_end    = value;
         REG_MAX_FAILURES: st.cfg.max_failures = value[3:0];
         default: ;  // indexes past the register file are dropped
      endcase
   endfunction

   // advances the lock by one item and returns the result it must send
   function automatic lock_reply_type step_lock(inout lock_state_type st,
                                                input lock_item_type it);
      lock_reply_type r;
      logic           last;
      logic [7:0]     b;
      r    = '0;
      b    = it.byte_value;
      last = (st.digit_pos >= CODE_DIGITS - 1);
      if (it.opcode == OP_TICK) begin
         // motor and alarm timers only move on ticks, the byte is don't care
         if (st.motor_run) begin
            st.motor_cnt = st.motor_cnt + 8'd1;
            if (st.motor_cnt == st.cfg.close_end) begin
               st.motor_lvl = DRIVE_STOP;
               st.motor_run = 1'b0;
               st.motor_cnt = '0;
            end else if (st.motor_cnt < st.cfg.cw_end) begin
               st.motor_lvl = DRIVE_CW;
            end else if (st.motor_cnt < st.cfg.hold_end) begin
               st.motor_lvl = DRIVE_STOP;
            end else begin
               st.motor_lvl = DRIVE_ACW;
            end
         end
         if (st.alarm_run) begin
            st.alarm_cnt = st.alarm_cnt + 8'd1;
            if (st.alarm_cnt == st.cfg.alarm_end) begin
               st.alarm_run = 1'b0;
               st.alarm_cnt = '0;
            end
         end
      end else begin
         case (st.mode)
            LOCK_SETUP_FIRST: begin
               st.entry_buf[st.digit_pos] = b;
               if (last) begin
                  st.mode     = LOCK_SETUP_SECOND;
                  st.mismatch = 1'b0;
               end
            end
            LOCK_SETUP_SECOND: begin
               if (st.entry_buf[st.digit_pos] != b) st.mismatch = 1'b1;
               if (last) begin
                  r.reply_valid = 1'b1;
                  r.reply_code  = st.mismatch;
                  if (st.mismatch) begin
                     st.mode = LOCK_SETUP_FIRST;
                  end else begin
                     st.code_store = st.entry_buf;
                     st.mode       = LOCK_IDLE;
                  end
                  st.mismatch = 1'b0;
               end
            end
            LOCK_IDLE: begin
               // anything but the two commands is dropped
               if (b == CMD_OPEN) begin
                  st.mode     = LOCK_OPEN_CHECK;
                  st.mismatch = 1'b0;
               end else if (b == CMD_CHANGE) begin
                  st.mode     = LOCK_CHANGE_CHECK;
                  st.mismatch = 1'b0;
               end
               last = 1'b1;  // digit position stays at zero
            end
            LOCK_OPEN_CHECK, LOCK_CHANGE_CHECK: begin
               if (st.code_store[st.digit_pos] != b) st.mismatch = 1'b1;
               if (last) begin
                  r.reply_valid = 1'b1;
                  r.reply_code  = st.mismatch;
                  if (st.mismatch) begin
                     // failed check: repeat it unless the failure limit is hit
                     st.fail_count = st.fail_count + 4'd1;
                     if (st.fail_count == st.cfg.max_failures) begin
                        st.fail_count = '0;
                        if (!st.alarm_run) begin
                           st.alarm_run = 1'b1;
                           st.alarm_cnt = '0;
                        end
                        st.mode = LOCK_IDLE;
                     end
                  end else begin
                     st.fail_count = '0;
                     if (st.mode == LOCK_OPEN_CHECK) begin
                        // a running door sequence is left as it is
                        if (!st.motor_run) begin
                           st.motor_run = 1'b1;
                           st.motor_cnt = '0;
                        end
                        st.mode = LOCK_IDLE;
                     end else begin
                        st.mode = LOCK_SETUP_FIRST;
                     end
                  end
                  st.mismatch = 1'b0;
               end
            end
            default: begin
               st.mode     = LOCK_IDLE;
               st.mismatch = 1'b0;
               last        = 1'b1;
            end
         endcase
         st.digit_pos = last ? 4'd0 : st.digit_pos + 4'd1;
      end
      r.motor_drive = st.motor_lvl;
      r.siren_on    = st.alarm_run && (st.alarm_cnt != 8'd0);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------

   task automatic queue_item(input logic opcode, input logic [7:0] byte_value);
      lock_item_type  it;
      lock_reply_type unused;
      it.opcode     = opcode;
      it.byte_value = byte_value;
      // bytes the idle lock drops do not count toward the stimulus size
      if (!(opcode == OP_BYTE && gen_view.mode == LOCK_IDLE &&
            byte_value != CMD_OPEN && byte_value != CMD_CHANGE))
         planned++;
      unused = step_lock(gen_view, it);
      lock_inputs_q.push_back(it);
   endtask

   task automatic queue_digit(input logic [7:0] digit);
      if ($urandom_range(99) < tick_mix_pct)
         repeat ($urandom_range(1, 3)) queue_item(OP_TICK, 8'($urandom));
      queue_item(OP_BYTE, digit);
   endtask

   // one full code entry, optionally with a single digit spoiled
   task automatic queue_code(input logic [CODE_DIGITS-1:0][7:0] code, input bit corrupt);
      int bad_pos;
      bad_pos = $urandom_range(CODE_DIGITS - 1);
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (corrupt && i == bad_pos)
            queue_digit(code[i] ^ 8'($urandom_range(1, 255)));
         else
            queue_digit(code[i]);
      end
   endtask

   // mostly well-formed lock sessions steered by the lookahead state, with
   // loose ticks and stray bytes mixed in
   task automatic queue_traffic(input int count);
      int                          goal;
      int                          pick;
      logic [CODE_DIGITS-1:0][7:0] code;
      goal = planned + count;
      while (planned < goal) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            queue_item(OP_TICK, 8'($urandom));
         end else if (pick < 30) begin
            queue_item(OP_BYTE, 8'($urandom));
         end else begin
            case (gen_view.mode)
               LOCK_SETUP_FIRST: begin
                  // new code, or the old one entered again now and then
                  if ($urandom_range(99) < 20) begin
                     code = gen_view.code_store;
                  end else begin
                     for (int i = 0; i < CODE_DIGITS; i++) code[i] = 8'($urandom);
                  end
                  queue_code(code, 1'b0);
                  queue_code(code, $urandom_range(99) < 15);
               end
               LOCK_SETUP_SECOND:
                  queue_code(gen_view.entry_buf, $urandom_range(99) < 15);
               LOCK_IDLE: begin
                  queue_digit(($urandom_range(99) < 60) ? CMD_OPEN : CMD_CHANGE);
                  queue_code(gen_view.code_store, $urandom_range(99) < 35);
               end
               default:
                  queue_code(gen_view.code_store, $urandom_range(99) < 35);
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // register writes, called only while no item is in flight, and synchronization
   // ---------------------------------------------------------------------------

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      apply_reg(gen_view, addr, value);
      apply_reg(dut_view, addr, value);
   endtask

   task automatic program_timing(input logic [7:0] cw, input logic [7:0] hold,
                                 input logic [7:0] close, input logic [7:0] alarm,
                                 input logic [3:0] max_fail);
      write_reg(REG_CW_END, cw);
      write_reg(REG_HOLD_END, hold);
      write_reg(REG_CLOSE_END, close);
      write_reg(REG_ALARM_END, alarm);
      // upper data bits are junk for the 4-bit register
      write_reg(REG_MAX_FAILURES, {4'($urandom), max_fail});
      // a write past the register file must change nothing
      write_reg(REG_MAX_FAILURES + CSR_ADDR_W'($urandom_range(1, 3)), 8'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // sender holds off until every queued item has gone and every result is back
   task automatic wait_drained();
      @(negedge clock);
      while (lock_inputs_q.size() != 0 || req_tvalid || replies_due.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // driver: offers queued items on req, predicts on every transfer
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : drive_proc
      lock_reply_type due;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due = step_lock(dut_view, in_flight);
            replies_due.push_back(due);
            items_sent++;
            if (in_flight.opcode == OP_TICK) ticks_sent++;
         end
         // only move on once the offered item has been taken
         if (!req_tvalid || req_tready) begin
            if (lock_inputs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight  = lock_inputs_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= in_flight.byte_value;
               req_tuser  <= in_flight.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: compares every rsp transfer with the oldest prediction
   // ---------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin : observe_proc
      lock_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $error("rsp transfer with nothing outstanding, tdata %0h", rsp_tdata);
               error_total++;
            end else begin
               want = replies_due.pop_front();
               check_field("reply_valid", 8'(want.reply_valid), 8'(rsp_tdata[0]));
               check_field("reply_code", 8'(want.reply_code), 8'(rsp_tdata[1]));
               check_field("motor_drive", 8'(want.motor_drive), 8'(rsp_tdata[3:2]));
               check_field("siren_on", 8'(want.siren_on), 8'(rsp_tdata[4]));
               check_field("rsp_tdata padding", 8'd0, 8'(rsp_tdata[7:5]));
               if (want.reply_valid && !want.reply_code) checks_ok++;
               if (want.reply_valid && want.reply_code) checks_bad++;
               if (want.siren_on) buzzer_seen++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: any transfer on either side counts as progress
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, replies_due.size());
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------

   initial begin : stimulus_proc
      logic [CODE_DIGITS-1:0][7:0] first_code;
      int                          phase;

      gen_view = lock_reset_state();
      dut_view = lock_reset_state();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (phase = 0; phase < PHASES; phase++) begin
         // receiver-heavy stalling first, then sender-heavy idling, then full rate
         if (phase < 2) begin
            send_idle_pct  = 33;
            recv_stall_pct = 71;
         end else if (phase < 4) begin
            send_idle_pct  = 71;
            recv_stall_pct = 33;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end

         case (phase)
            1: program_timing(8'd1, 8'd1, 8'd1, 8'd1, 4'd1);           // shortest runs
            2: program_timing(8'd255, 8'd255, 8'd255, 8'd255, 4'd15);  // longest runs
            3: program_timing(8'd3, 8'd5, 8'd9, 8'd12, 4'd2);
            4: program_timing(8'd0, 8'd0, 8'd0, 8'd0, 4'd0);           // counters wrap
            5: program_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                              4'($urandom_range(1, 15)));
            default: ;  // reset timings
         endcase

         if (phase == 0) begin
            // directed: code with extreme and command-like digits, entered twice
            tick_mix_pct = 0;
            first_code   = {8'hA5, CMD_CHANGE, CMD_OPEN, 8'hFF, 8'h00};
            queue_code(first_code, 1'b0);
            queue_code(first_code, 1'b0);
            queue_item(OP_TICK, 8'hFF);      // byte field ignored on a tick
            queue_item(OP_BYTE, 8'h00);      // stray byte while idle
            queue_item(OP_BYTE, CMD_OPEN);
            queue_code(first_code, 1'b0);    // door sequence starts
            queue_item(OP_TICK, 8'h00);
            queue_item(OP_BYTE, CMD_CHANGE);
            queue_code(first_code, 1'b1);    // wrong code, check repeats
         end

         tick_mix_pct = 20;
         queue_traffic(HALF_PHASE);
         wait_drained();
         queue_traffic(HALF_PHASE);
         wait_drained();
      end

      repeat (SETTLE_TICKS) @(negedge clock);

      $display("covered %0d items (%0d ticks) over %0d timing settings with varied idling",
               items_sent, ticks_sent, PHASES);
      $display("code checks: %0d matched, %0d mismatched; buzzer on in %0d results",
               checks_ok, checks_bad, buzzer_seen);
      if (error_total == 0 && replies_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
